// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

// ===== design/nru_pkg.sv =====
// ----------------------------------------------------------------------------
// nru_pkg
// Types and constants shared by the NRU page replacement unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nru_pkg;

   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned INSTR_W    = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned PAGE_W     = 13;
   localparam int unsigned THR_W      = 16;
   localparam int unsigned FIDX_W     = 6;

   // divide by ten: (x * 52429) >> 19, exact for 16-bit x
   localparam int unsigned PAGE_DIV    = 10;
   localparam int unsigned RECIP_W     = 17;
   localparam logic [RECIP_W-1:0] DIV10_RECIP = 17'd52429;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam int unsigned PROD_W      = ADDR_W + RECIP_W;

   localparam logic [INSTR_W-1:0] MODIFY_DIGIT = 16'd1;
   localparam logic [THR_W-1:0]   AGE_RESET    = 16'd20;

   typedef struct packed {
      logic [ADDR_W-1:0]  access_address;
      logic [INSTR_W-1:0] instruction_word;
      logic [TIME_W-1:0]  timestamp;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [FIDX_W-1:0] frame_index;
      logic              evicted_valid;
      logic [PAGE_W-1:0] evicted_page;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [TIME_W-1:0] load_time;
      logic              referenced;
      logic              modified;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic scan_start;
      logic scan_run;
      logic age_mode;
      logic hit_wr;
      logic load;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic hit_found;
      logic scan_done;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/nru_stream_if.sv =====
// ----------------------------------------------------------------------------
// nru_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nru_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/nru_ctrl.sv =====
// ----------------------------------------------------------------------------
// nru_ctrl
// Sequencer for lookup, aging/victim scan, frame load and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nru_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  nru_pkg::sts_type sts,
   output nru_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_HSCAN = 3'd2;
   localparam logic [2:0] S_AGE   = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep       = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = S_HSCAN;
         end
         S_HSCAN: begin
            if (sts.hit_found) begin
               cmd.hit_wr = 1'b1;
               state_in   = S_DONE;
            end else if (sts.scan_done) begin
               cmd.scan_start = 1'b1;
               state_in       = S_AGE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_AGE: begin
            cmd.age_mode = 1'b1;
            if (sts.scan_done) begin
               state_in = S_LOAD;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/nru_dpath.sv =====
// ----------------------------------------------------------------------------
// nru_dpath
// Frame table memory, scan pipeline, aging and class-minimum tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nru_dpath #(
   parameter int FRAMES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nru_pkg::cmd_type              cmd,
   output nru_pkg::sts_type              sts,
   input  nru_pkg::req_type              req_data,
   input  logic                          csr_wr,
   input  logic [nru_pkg::THR_W-1:0]     csr_data,
   output nru_pkg::rsp_type              rsp_data
);

   localparam int IDX_W = $clog2(FRAMES);
   localparam int CNT_W = $clog2(FRAMES + 1);

   nru_pkg::entry_type mem [FRAMES];

   logic [nru_pkg::THR_W-1:0]   thr_ff;
   logic [nru_pkg::ADDR_W-1:0]  addr_ff;
   logic [nru_pkg::INSTR_W-1:0] instr_ff;
   logic [nru_pkg::TIME_W-1:0]  now_ff;
   logic [nru_pkg::PAGE_W-1:0]  page_ff;
   logic                        mod_ff;
   logic [CNT_W-1:0]            fill_ff;
   logic [CNT_W-1:0]            scan_ff;
   logic                        rd_vld_ff;
   logic [IDX_W-1:0]            rd_idx_ff;
   nru_pkg::entry_type          rdata_ff;
   logic                        found_ff;
   logic [IDX_W-1:0]            target_ff;
   logic [2:0]                  best_ff;
   logic [nru_pkg::PAGE_W-1:0]  ev_page_ff;
   logic                        ev_valid_ff;
   nru_pkg::rsp_type            rsp_ff;

   logic [nru_pkg::PROD_W-1:0]  addr_prod;
   logic [nru_pkg::PROD_W-1:0]  instr_prod;
   logic [nru_pkg::PAGE_W-1:0]  instr_quot;
   logic [nru_pkg::INSTR_W-1:0] instr_tens;
   logic [nru_pkg::INSTR_W-1:0] instr_rem;
   logic                        scan_more;
   logic                        full;
   logic [IDX_W-1:0]            load_idx;
   logic [nru_pkg::TIME_W-1:0]  age;
   logic                        age_ref;
   logic [1:0]                  cls;
   logic                        age_we;
   logic                        mem_we;
   logic [IDX_W-1:0]            wr_addr;
   nru_pkg::entry_type          wr_data;

   assign addr_prod  = {{nru_pkg::RECIP_W{1'b0}}, addr_ff}
                       * {{nru_pkg::ADDR_W{1'b0}}, nru_pkg::DIV10_RECIP};
   assign instr_prod = {{nru_pkg::RECIP_W{1'b0}}, instr_ff}
                       * {{nru_pkg::INSTR_W{1'b0}}, nru_pkg::DIV10_RECIP};
   assign instr_quot = instr_prod[nru_pkg::RECIP_SHIFT +: nru_pkg::PAGE_W];
   assign instr_tens = {instr_quot, 3'b000} + {2'b00, instr_quot, 1'b0};
   assign instr_rem  = instr_ff - instr_tens;

   assign scan_more = (scan_ff < fill_ff);
   assign full      = (fill_ff == CNT_W'(FRAMES));
   assign load_idx  = full ? target_ff : fill_ff[IDX_W-1:0];

   assign age     = now_ff - rdata_ff.load_time;
   assign age_ref = rdata_ff.referenced
                    && !(age > {{(nru_pkg::TIME_W - nru_pkg::THR_W){1'b0}}, thr_ff});
   assign cls     = {age_ref, rdata_ff.modified};
   assign age_we  = cmd.age_mode && cmd.scan_run && rd_vld_ff;

   assign sts.hit_found = rd_vld_ff && (rdata_ff.page == page_ff);
   assign sts.scan_done = !scan_more && !rd_vld_ff;

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rdata_ff;
      if (cmd.load) begin
         mem_we             = 1'b1;
         wr_addr            = load_idx;
         wr_data.page       = page_ff;
         wr_data.load_time  = now_ff;
         wr_data.referenced = 1'b1;
         wr_data.modified   = mod_ff;
      end else if (cmd.hit_wr) begin
         mem_we             = 1'b1;
         wr_data.referenced = 1'b1;
         wr_data.modified   = rdata_ff.modified | mod_ff;
      end else if (age_we) begin
         mem_we             = 1'b1;
         wr_data.referenced = age_ref;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.scan_run && scan_more) begin
         rdata_ff <= mem[scan_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= nru_pkg::AGE_RESET;
         fill_ff   <= '0;
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            thr_ff <= csr_data;
         end
         if (cmd.load && !full) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.scan_start) begin
            scan_ff   <= '0;
            rd_vld_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            rd_vld_ff <= scan_more;
            if (scan_more) begin
               scan_ff <= scan_ff + 1'b1;
            end
         end else begin
            rd_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff  <= req_data.access_address;
         instr_ff <= req_data.instruction_word;
         now_ff   <= req_data.timestamp;
      end
      if (cmd.prep) begin
         page_ff <= addr_prod[nru_pkg::RECIP_SHIFT +: nru_pkg::PAGE_W];
         mod_ff  <= (instr_rem == nru_pkg::MODIFY_DIGIT);
      end
      if (cmd.scan_run && scan_more) begin
         rd_idx_ff <= scan_ff[IDX_W-1:0];
      end
      if (cmd.scan_start) begin
         best_ff <= 3'd4;
      end else if (age_we && ({1'b0, cls} < best_ff)) begin
         best_ff    <= {1'b0, cls};
         target_ff  <= rd_idx_ff;
         ev_page_ff <= rdata_ff.page;
      end
      if (cmd.hit_wr) begin
         found_ff    <= 1'b1;
         target_ff   <= rd_idx_ff;
         ev_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         found_ff    <= 1'b0;
         target_ff   <= load_idx;
         ev_valid_ff <= full;
      end
      if (cmd.rsp_load) begin
         rsp_ff.hit           <= found_ff;
         rsp_ff.frame_index   <= nru_pkg::FIDX_W'(target_ff);
         rsp_ff.evicted_valid <= ev_valid_ff;
         rsp_ff.evicted_page  <= ev_valid_ff ? ev_page_ff : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== design/nru_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// nru_page_replacement_unit
// Not-recently-used page replacement over a table of FRAMES frames.
//
//   channel   dir  payload                                   transfer when
//   req_chan  in   access_address, instruction_word, time    valid && ready
//   rsp_chan  out  hit, frame_index, evicted_valid/page      valid && ready
//   csr_chan  in   age_threshold (16 bit)                    valid && ready
//
// One access at a time; the frame table is a single memory scanned one
// entry per cycle. A hit ends the lookup scan at its frame; a miss runs the
// lookup scan over all filled frames, then the aging and victim scan.
// Synchronous reset empties the table at once (fill count).
// A waiting result is held in its output register while the next access is
// taken; the following result waits for that register to free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nru_page_replacement_unit #(
   parameter int FRAMES = 64
) (
   input  logic         clock,
   input  logic         reset,
   nru_stream_if.sink   req_chan,
   nru_stream_if.source rsp_chan,
   nru_stream_if.sink   csr_chan
);

   nru_pkg::cmd_type cmd;
   nru_pkg::sts_type sts;
   nru_pkg::rsp_type rsp_data;

   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.payload = rsp_data;

   nru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nru_dpath #(
      .FRAMES (FRAMES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_chan.payload),
      .csr_wr   (csr_chan.valid),
      .csr_data (csr_chan.payload),
      .rsp_data (rsp_data)
   );

   `ASSERT_CLK_RST(a_accept_prep, clock, reset, (req_chan.valid && req_chan.ready) |=> cmd.prep, "accepted access not prepared")
   `ASSERT_CLK_RST(a_rsp_rise, clock, reset, $rose(rsp_chan.valid) |-> $past(cmd.rsp_load), "result raised without load")
   `ASSERT_CLK_RST(a_idle_no_scan, clock, reset, req_chan.ready |-> !(cmd.scan_run || cmd.load || cmd.hit_wr), "table activity while idle")
   `ASSERT_CLK(a_one_writer, clock, !(cmd.load && cmd.hit_wr), "load and hit update together")

endmodule

`default_nettype wire
